>>> hw/rtl/c3v_pkg.sv
// shared types, widths and helpers for the 3x3 convolution stream unit
package c3v_pkg;

    localparam int PIX_W       = 8;
    localparam int SLOT_W      = 16;
    localparam int COEF_BITS   = 16;
    localparam int ROW_REG_W   = 3 * SLOT_W;
    localparam int MAX_WIDTH   = 1024;
    localparam int LS_ADDR_W   = $clog2(MAX_WIDTH);
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int WIDTH_REG_W = 11;
    localparam int HGT_REG_W   = 13;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_SIDE    = 3;
    localparam int WIDTH_RESET = 1024;
    localparam int HGT_RESET   = 1024;

    localparam int PROD_W      = SLOT_W + PIX_W + 1;
    localparam int PSUM_W      = PROD_W + 2;
    localparam int SUM_W       = PSUM_W + 2;
    localparam int OUT_W       = 28;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = ROW_REG_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

    // one 3x3 window, pix[r*3+k] is row r (oldest first), column k (leftmost first)
    typedef struct packed {
        logic [8:0][PIX_W-1:0] pix;
        logic                  last;
    } t_win_entry;

    typedef struct packed {
        logic [ROW_REG_W-1:0] top;
        logic [ROW_REG_W-1:0] middle;
        logic [ROW_REG_W-1:0] bottom;
    } t_kernel;

    // low COEF_BITS of a 16-bit slot as two's complement, sign-extended to the slot
    function automatic logic signed [SLOT_W-1:0] coef(input logic [ROW_REG_W-1:0] row_bits,
                                                      input int unsigned col);
        logic [SLOT_W-1:0]          slot;
        logic signed [COEF_BITS-1:0] c;
        slot = row_bits[col*SLOT_W +: SLOT_W];
        c    = $signed(slot[COEF_BITS-1:0]);
        return SLOT_W'(c);
    endfunction

endpackage

>>> hw/rtl/c3v_ram.sv
// generic simple dual-port ram with registered read
module c3v_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/c3v_front.sv
// front end: pixel intake, line stores, window forming and result classification
module c3v_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [c3v_pkg::PIX_W-1:0]           i_pixel,
    input  logic [c3v_pkg::WIDTH_REG_W-1:0]     i_image_width,
    input  logic [c3v_pkg::HGT_REG_W-1:0]       i_image_height,
    input  logic [c3v_pkg::Q_CNT_W-1:0]         i_q_count,
    output logic                                o_push,
    output c3v_pkg::t_win_entry                 o_entry
);

    logic [c3v_pkg::COL_W-1:0]       r_col;
    logic [c3v_pkg::ROW_W-1:0]       r_row;
    logic [c3v_pkg::COL_W-1:0]       n_col;
    logic [c3v_pkg::ROW_W-1:0]       n_row;
    logic                            r_s1_valid;
    logic                            r_s1_prod;
    logic                            r_s1_last;
    logic [c3v_pkg::PIX_W-1:0]       r_s1_px;
    logic [c3v_pkg::LS_ADDR_W-1:0]   r_s1_idx;
    logic [c3v_pkg::PIX_W-1:0]       r_wcol0 [3];
    logic [c3v_pkg::PIX_W-1:0]       r_wcol1 [3];
    logic [c3v_pkg::WIDTH_REG_W-1:0] eff_w;
    logic [c3v_pkg::HGT_REG_W-1:0]   eff_h;
    logic [c3v_pkg::WIDTH_REG_W-1:0] col_inc;
    logic [c3v_pkg::HGT_REG_W-1:0]   row_inc;
    logic                            col_end;
    logic                            row_end;
    logic                            accept;
    logic [2*c3v_pkg::PIX_W-1:0]     ls_rdata;
    logic [c3v_pkg::PIX_W-1:0]       older;
    logic [c3v_pkg::PIX_W-1:0]       prev;
    logic [c3v_pkg::Q_CNT_W-1:0]     pending;

    always_comb begin
        if (i_image_width < c3v_pkg::WIDTH_REG_W'(c3v_pkg::MIN_SIDE)) begin
            eff_w = c3v_pkg::WIDTH_REG_W'(c3v_pkg::MIN_SIDE);
        end else if (i_image_width > c3v_pkg::WIDTH_REG_W'(c3v_pkg::MAX_WIDTH)) begin
            eff_w = c3v_pkg::WIDTH_REG_W'(c3v_pkg::MAX_WIDTH);
        end else begin
            eff_w = i_image_width;
        end
        if (i_image_height < c3v_pkg::HGT_REG_W'(c3v_pkg::MIN_SIDE)) begin
            eff_h = c3v_pkg::HGT_REG_W'(c3v_pkg::MIN_SIDE);
        end else if (i_image_height > c3v_pkg::HGT_REG_W'(c3v_pkg::HEIGHT_LIMIT)) begin
            eff_h = c3v_pkg::HGT_REG_W'(c3v_pkg::HEIGHT_LIMIT);
        end else begin
            eff_h = i_image_height;
        end
    end

    // a beat in stage one that produces a result still needs a queue slot
    assign pending = i_q_count + c3v_pkg::Q_CNT_W'(r_s1_valid & r_s1_prod);
    assign o_ready = pending < c3v_pkg::Q_CNT_W'(c3v_pkg::Q_DEPTH);
    assign accept  = i_valid & o_ready;

    assign col_inc = c3v_pkg::WIDTH_REG_W'(r_col) + 1'b1;
    assign row_inc = c3v_pkg::HGT_REG_W'(r_row) + 1'b1;
    assign col_end = col_inc >= eff_w;
    assign row_end = row_inc >= eff_h;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : row_inc[c3v_pkg::ROW_W-1:0];
            end else begin
                n_col = col_inc[c3v_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_wcol0[i] <= '0;
                r_wcol1[i] <= '0;
            end
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
            if (r_s1_valid) begin
                r_wcol0[0] <= r_wcol1[0];
                r_wcol0[1] <= r_wcol1[1];
                r_wcol0[2] <= r_wcol1[2];
                r_wcol1[0] <= older;
                r_wcol1[1] <= prev;
                r_wcol1[2] <= r_s1_px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px   <= i_pixel;
            r_s1_idx  <= r_col[c3v_pkg::LS_ADDR_W-1:0];
            r_s1_prod <= (r_row >= c3v_pkg::ROW_W'(2)) && (r_col >= c3v_pkg::COL_W'(2));
            r_s1_last <= col_end && row_end;
        end
    end

    // both line stores share one ram: high byte older row, low byte previous row
    c3v_ram #(
        .WIDTH (2 * c3v_pkg::PIX_W),
        .DEPTH (c3v_pkg::MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_idx),
        .i_wdata ({prev, r_s1_px}),
        .i_re    (accept),
        .i_raddr (r_col[c3v_pkg::LS_ADDR_W-1:0]),
        .o_rdata (ls_rdata)
    );

    assign older = ls_rdata[2*c3v_pkg::PIX_W-1:c3v_pkg::PIX_W];
    assign prev  = ls_rdata[c3v_pkg::PIX_W-1:0];

    assign o_push = r_s1_valid & r_s1_prod;

    always_comb begin
        o_entry.pix[0] = r_wcol0[0];
        o_entry.pix[1] = r_wcol1[0];
        o_entry.pix[2] = older;
        o_entry.pix[3] = r_wcol0[1];
        o_entry.pix[4] = r_wcol1[1];
        o_entry.pix[5] = prev;
        o_entry.pix[6] = r_wcol0[2];
        o_entry.pix[7] = r_wcol1[2];
        o_entry.pix[8] = r_s1_px;
        o_entry.last   = r_s1_last;
    end

endmodule

>>> hw/rtl/c3v_queue.sv
// short window queue between front end and multiply-accumulate back end
module c3v_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  c3v_pkg::t_win_entry         i_entry,
    input  logic                        i_pop,
    output logic                        o_empty,
    output c3v_pkg::t_win_entry         o_entry,
    output logic [c3v_pkg::Q_CNT_W-1:0] o_count
);

    c3v_pkg::t_win_entry             r_mem [c3v_pkg::Q_DEPTH];
    logic [c3v_pkg::Q_PTR_W-1:0]     r_wptr;
    logic [c3v_pkg::Q_PTR_W-1:0]     r_rptr;
    logic [c3v_pkg::Q_CNT_W-1:0]     r_count;
    logic                            do_pop;

    assign o_empty = r_count == '0;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + c3v_pkg::Q_CNT_W'(i_push) - c3v_pkg::Q_CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    assign o_entry = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

>>> hw/rtl/c3v_back.sv
// back end: nine products, two adder levels and the output register
module c3v_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  c3v_pkg::t_kernel                  i_kernel,
    input  logic                              i_q_empty,
    input  c3v_pkg::t_win_entry               i_entry,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [c3v_pkg::OUT_W-1:0]  o_value,
    output logic                              o_last
);

    logic signed [c3v_pkg::PROD_W-1:0] r_prod [9];
    logic signed [c3v_pkg::PROD_W-1:0] prod [9];
    logic signed [c3v_pkg::PSUM_W-1:0] r_psum [3];
    logic signed [c3v_pkg::SUM_W-1:0]  total;
    logic signed [c3v_pkg::OUT_W-1:0]  r_out;
    logic                              r_a_valid;
    logic                              r_a_last;
    logic                              r_b_valid;
    logic                              r_b_last;
    logic                              r_c_valid;
    logic                              r_c_last;
    logic                              adv;
    logic [c3v_pkg::ROW_REG_W-1:0]     krow [3];

    assign krow[0] = i_kernel.top;
    assign krow[1] = i_kernel.middle;
    assign krow[2] = i_kernel.bottom;

    // whole pipe moves unless the output beat is stuck
    assign adv   = ~r_c_valid | i_ready;
    assign o_pop = adv & ~i_q_empty;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod[r*3+k] = c3v_pkg::PROD_W'(c3v_pkg::coef(krow[r], k))
                            * c3v_pkg::PROD_W'($signed({1'b0, i_entry.pix[r*3+k]}));
            end
        end
    end

    assign total = c3v_pkg::SUM_W'(r_psum[0]) + c3v_pkg::SUM_W'(r_psum[1])
                 + c3v_pkg::SUM_W'(r_psum[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= ~i_q_empty;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) begin
                r_prod[i] <= prod[i];
            end
            r_a_last <= i_entry.last;
            for (int r = 0; r < 3; r++) begin
                r_psum[r] <= c3v_pkg::PSUM_W'(r_prod[r*3]) + c3v_pkg::PSUM_W'(r_prod[r*3+1])
                           + c3v_pkg::PSUM_W'(r_prod[r*3+2]);
            end
            r_b_last <= r_a_last;
            r_out    <= total[c3v_pkg::OUT_W-1:0];
            r_c_last <= r_b_last;
        end
    end

    assign o_valid = r_c_valid;
    assign o_value = r_out;
    assign o_last  = r_c_last;

endmodule

>>> hw/rtl/conv3x3_valid_stream_unit.sv
// top level of the 3x3 valid convolution stream unit with its configuration registers
// throughput: one pixel per cycle while the window queue has room, set by the shared
//   line-store ram (read at intake, written back from the stage-one register) and
//   the fully pipelined nine-multiplier back end
// reset clears counters, window columns, queue and pipe valids and the configuration
//   (kernel zero, width and height 1024); line-store contents are not cleared
module conv3x3_valid_stream_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [c3v_pkg::PIX_W-1:0]              i_s_tdata,   // [7:0] pixel
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [c3v_pkg::OUT_TDATA_W-1:0]        o_m_tdata,   // [27:0] filtered_value, rest zero
    output logic                                   o_m_tlast,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [c3v_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [c3v_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    c3v_pkg::t_kernel                    r_kernel;
    logic [c3v_pkg::WIDTH_REG_W-1:0]     r_width;
    logic [c3v_pkg::HGT_REG_W-1:0]       r_height;
    logic                                push;
    logic                                pop;
    logic                                q_empty;
    logic [c3v_pkg::Q_CNT_W-1:0]         q_count;
    c3v_pkg::t_win_entry                 front_entry;
    c3v_pkg::t_win_entry                 q_entry;
    logic signed [c3v_pkg::OUT_W-1:0]    value;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= '0;
            r_width  <= c3v_pkg::WIDTH_REG_W'(c3v_pkg::WIDTH_RESET);
            r_height <= c3v_pkg::HGT_REG_W'(c3v_pkg::HGT_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                c3v_pkg::REG_KERNEL_TOP:    r_kernel.top    <= i_cfg_data;
                c3v_pkg::REG_KERNEL_MIDDLE: r_kernel.middle <= i_cfg_data;
                c3v_pkg::REG_KERNEL_BOTTOM: r_kernel.bottom <= i_cfg_data;
                c3v_pkg::REG_IMAGE_WIDTH:   r_width  <= i_cfg_data[c3v_pkg::WIDTH_REG_W-1:0];
                c3v_pkg::REG_IMAGE_HEIGHT:  r_height <= i_cfg_data[c3v_pkg::HGT_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    c3v_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .o_ready        (o_s_tready),
        .i_pixel        (i_s_tdata),
        .i_image_width  (r_width),
        .i_image_height (r_height),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_entry        (front_entry)
    );

    c3v_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (q_entry),
        .o_count (q_count)
    );

    c3v_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kernel  (r_kernel),
        .i_q_empty (q_empty),
        .i_entry   (q_entry),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_value   (value),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {{(c3v_pkg::OUT_TDATA_W - c3v_pkg::OUT_W){1'b0}}, value};

endmodule

>>> tb/sv/conv3x3_valid_stream_unit_tb.sv
// self-checking testbench for the 3x3 valid convolution stream unit
`timescale 1ns / 100ps

module conv3x3_valid_stream_unit_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 12;
    localparam int IDLE_PCT       = 29;
    localparam int HOLD_CYCLES    = 250;
    localparam int TALL_ITEMS     = 360;
    localparam int RANDOM_ITEMS   = 600;
    localparam int SHOW_MAX       = 10;
    localparam int DRAIN_LIMIT    = 100000;
    localparam int TIMEOUT_CYCLES = 1000000;
    localparam int HEIGHT_FIELD_MAX = (1 << c3v_pkg::HGT_REG_W) - 1;
    localparam int WIDTH_FIELD_MAX  = (1 << c3v_pkg::WIDTH_REG_W) - 1;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [c3v_pkg::PIX_W-1:0]       i_s_tdata;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [c3v_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            o_m_tlast;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [c3v_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [c3v_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    conv3x3_valid_stream_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    typedef struct {
        logic [c3v_pkg::OUT_W-1:0] value;
        logic                      last;
    } t_filt_result;

    typedef struct {
        bit                             is_cfg;
        logic [c3v_pkg::CFG_IDX_W-1:0]  idx;
        logic [c3v_pkg::CFG_DATA_W-1:0] data;
        logic [c3v_pkg::PIX_W-1:0]      px;
        bit                             typed;
        t_filt_result                   want;
    } t_stim_row;

    t_filt_result pending_results[$];
    t_stim_row    stim_rows[$];

    // predictor copy of the configuration and datapath state
    logic [c3v_pkg::ROW_REG_W-1:0]   kern_rows [3];
    logic [c3v_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [c3v_pkg::HGT_REG_W-1:0]   height_reg;
    logic [c3v_pkg::PIX_W-1:0]       line_prev [c3v_pkg::MAX_WIDTH];
    logic [c3v_pkg::PIX_W-1:0]       line_old  [c3v_pkg::MAX_WIDTH];
    logic [c3v_pkg::PIX_W-1:0]       win_cols  [6];
    int unsigned                     col_cnt;
    int unsigned                     row_cnt;

    int errors;
    int pixels_sent;
    int results_seen;
    int frames_seen;
    int cfg_writes;
    int hold_req;
    bit no_idle;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("conv3x3_valid_stream_unit: mismatch");
        $finish;
    end

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= SHOW_MAX) $display("%s", msg);
    endfunction

    function automatic int unsigned width_clamp(input logic [c3v_pkg::WIDTH_REG_W-1:0] v);
        if (v < c3v_pkg::MIN_SIDE) return c3v_pkg::MIN_SIDE;
        if (v > c3v_pkg::MAX_WIDTH) return c3v_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic int unsigned eff_width();
        return width_clamp(width_reg);
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg < c3v_pkg::MIN_SIDE) return c3v_pkg::MIN_SIDE;
        if (height_reg > c3v_pkg::HEIGHT_LIMIT) return c3v_pkg::HEIGHT_LIMIT;
        return height_reg;
    endfunction

    // low COEF_BITS of slot k as two's complement
    function automatic longint coef_of(input logic [c3v_pkg::ROW_REG_W-1:0] row_bits,
                                       input int k);
        logic [c3v_pkg::SLOT_W-1:0]        slot;
        logic signed [c3v_pkg::SLOT_W-1:0] sx;
        slot = row_bits[k*c3v_pkg::SLOT_W +: c3v_pkg::SLOT_W];
        sx   = $signed(slot << (c3v_pkg::SLOT_W - c3v_pkg::COEF_BITS))
               >>> (c3v_pkg::SLOT_W - c3v_pkg::COEF_BITS);
        return longint'(sx);
    endfunction

    function automatic logic [c3v_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return c3v_pkg::PIX_W'($urandom());
        endcase
    endfunction

    function automatic logic [c3v_pkg::ROW_REG_W-1:0] rand_kernel_row();
        logic [c3v_pkg::ROW_REG_W-1:0] row;
        row = '0;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0: row[k*c3v_pkg::SLOT_W +: c3v_pkg::SLOT_W] = 16'h8000;
                1: row[k*c3v_pkg::SLOT_W +: c3v_pkg::SLOT_W] = 16'h7fff;
                2: row[k*c3v_pkg::SLOT_W +: c3v_pkg::SLOT_W] = 16'h0000;
                3: row[k*c3v_pkg::SLOT_W +: c3v_pkg::SLOT_W] = 16'h0001;
                4: row[k*c3v_pkg::SLOT_W +: c3v_pkg::SLOT_W] = 16'hffff;
                default: row[k*c3v_pkg::SLOT_W +: c3v_pkg::SLOT_W] =
                    c3v_pkg::SLOT_W'($urandom());
            endcase
        end
        return row;
    endfunction

    task automatic model_reset();
        for (int r = 0; r < 3; r++) kern_rows[r] = '0;
        width_reg  = c3v_pkg::WIDTH_REG_W'(c3v_pkg::WIDTH_RESET);
        height_reg = c3v_pkg::HGT_REG_W'(c3v_pkg::HGT_RESET);
        for (int i = 0; i < c3v_pkg::MAX_WIDTH; i++) begin
            line_prev[i] = '0;
            line_old[i]  = '0;
        end
        for (int i = 0; i < 6; i++) win_cols[i] = '0;
        col_cnt = 0;
        row_cnt = 0;
    endtask

    task automatic model_config(input logic [c3v_pkg::CFG_IDX_W-1:0] idx,
                                input logic [c3v_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            c3v_pkg::REG_KERNEL_TOP:    kern_rows[0] = data;
            c3v_pkg::REG_KERNEL_MIDDLE: kern_rows[1] = data;
            c3v_pkg::REG_KERNEL_BOTTOM: kern_rows[2] = data;
            c3v_pkg::REG_IMAGE_WIDTH:   width_reg    = data[c3v_pkg::WIDTH_REG_W-1:0];
            c3v_pkg::REG_IMAGE_HEIGHT:  height_reg   = data[c3v_pkg::HGT_REG_W-1:0];
            default: ;
        endcase
    endtask

    // advance the filter state by one pixel and form the window sum
    task automatic filter_step(input logic [c3v_pkg::PIX_W-1:0] px, output bit produced,
                               output t_filt_result res);
        int unsigned               w;
        int unsigned               h;
        int unsigned               c;
        int unsigned               ix;
        logic [c3v_pkg::PIX_W-1:0] older;
        logic [c3v_pkg::PIX_W-1:0] prev;
        logic [c3v_pkg::PIX_W-1:0] win [3][3];
        longint                    acc;
        longint                    pv;
        w  = eff_width();
        h  = eff_height();
        c  = col_cnt;
        ix = (c < c3v_pkg::MAX_WIDTH) ? c : c3v_pkg::MAX_WIDTH - 1;
        older = line_old[ix];
        prev  = line_prev[ix];
        line_old[ix]  = prev;
        line_prev[ix] = px;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win_cols[r];
            win[r][1] = win_cols[3 + r];
        end
        win[0][2] = older;
        win[1][2] = prev;
        win[2][2] = px;
        acc = 0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                pv  = win[r][k];
                acc = acc + coef_of(kern_rows[r], k) * pv;
            end
        end
        produced  = (row_cnt >= 2 && c >= 2);
        res.value = acc[c3v_pkg::OUT_W-1:0];
        res.last  = (c + 1 >= w) && (row_cnt + 1 >= h);
        for (int r = 0; r < 3; r++) begin
            win_cols[r]     = win[r][1];
            win_cols[3 + r] = win[r][2];
        end
        c++;
        if (c >= w) begin
            c = 0;
            row_cnt++;
            if (row_cnt >= h) row_cnt = 0;
        end
        col_cnt = c;
    endtask

    // stop offering pixels and wait for every pending result
    task automatic drain_source();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (pending_results.size() != 0 && guard < DRAIN_LIMIT);
    endtask

    task automatic write_reg(input logic [c3v_pkg::CFG_IDX_W-1:0] idx,
                             input logic [c3v_pkg::CFG_DATA_W-1:0] data);
        drain_source();
        // rows that give no result may still be in flight in the pipe
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_config(idx, data);
        cfg_writes++;
    endtask

    task automatic send_pixel(input logic [c3v_pkg::PIX_W-1:0] px, output bit produced,
                              output t_filt_result res);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        do @(posedge i_clk); while (!o_s_tready);
        filter_step(px, produced, res);
        pixels_sent++;
    endtask

    task automatic feed_pixel(input logic [c3v_pkg::PIX_W-1:0] px);
        bit           produced;
        t_filt_result res;
        send_pixel(px, produced, res);
        if (produced) pending_results.push_back(res);
    endtask

    task automatic add_cfg(input logic [c3v_pkg::CFG_IDX_W-1:0] idx,
                           input logic [c3v_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        stim_rows.push_back(row);
    endtask

    task automatic add_pix(input logic [c3v_pkg::PIX_W-1:0] px, input bit typed,
                           input int value, input bit last);
        t_stim_row row;
        row            = '{default: '0};
        row.px         = px;
        row.typed      = typed;
        row.want.value = c3v_pkg::OUT_W'(value);
        row.want.last  = last;
        stim_rows.push_back(row);
    endtask

    // output side: random backpressure, plus a long hold on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (no_idle) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_filt_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (o_m_tlast) frames_seen++;
            if (pending_results.size() == 0) begin
                note_error($sformatf("result beat with none pending: tdata=%h tlast=%b",
                                     o_m_tdata, o_m_tlast));
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== {{(c3v_pkg::OUT_TDATA_W - c3v_pkg::OUT_W){1'b0}},
                                   want.value})
                    note_error($sformatf("filtered_value: expected %0d actual %0d (tdata %h)",
                                         $signed(want.value),
                                         $signed(o_m_tdata[c3v_pkg::OUT_W-1:0]),
                                         o_m_tdata));
                if (o_m_tlast !== want.last)
                    note_error($sformatf("frame_last: expected %b actual %b",
                                         want.last, o_m_tlast));
            end
        end
    end

    initial begin
        bit                              produced;
        t_filt_result                    res;
        int                              phase;
        int                              len;
        int                              pause_at;
        int                              random_items;
        int                              pick;
        int unsigned                     w;
        int unsigned                     h;
        bit                              hold_phase;
        logic [c3v_pkg::WIDTH_REG_W-1:0] w_val;
        logic [c3v_pkg::HGT_REG_W-1:0]   h_val;
        logic [c3v_pkg::CFG_DATA_W-1:0]  junk;

        errors       = 0;
        pixels_sent  = 0;
        results_seen = 0;
        frames_seen  = 0;
        cfg_writes   = 0;
        hold_req     = 0;
        no_idle      = 1'b0;
        phase        = 0;
        random_items = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        model_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: both sides below range give a 3x3 image, full-scale kernels
        add_cfg(c3v_pkg::REG_IMAGE_WIDTH, '0);
        add_cfg(c3v_pkg::REG_IMAGE_HEIGHT, c3v_pkg::CFG_DATA_W'(2));
        add_cfg(c3v_pkg::REG_KERNEL_TOP,    {3{16'h8000}});
        add_cfg(c3v_pkg::REG_KERNEL_MIDDLE, {3{16'h8000}});
        add_cfg(c3v_pkg::REG_KERNEL_BOTTOM, {3{16'h8000}});
        repeat (8) add_pix(8'hff, 1'b0, 0, 1'b0);
        add_pix(8'hff, 1'b1, -75202560, 1'b1);
        add_cfg(c3v_pkg::REG_KERNEL_TOP,    {3{16'h7fff}});
        add_cfg(c3v_pkg::REG_KERNEL_MIDDLE, {3{16'h7fff}});
        add_cfg(c3v_pkg::REG_KERNEL_BOTTOM, {3{16'h7fff}});
        repeat (8) add_pix(8'hff, 1'b0, 0, 1'b0);
        add_pix(8'hff, 1'b1, 75200265, 1'b1);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg) begin
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            end else begin
                send_pixel(stim_rows[i].px, produced, res);
                if (stim_rows[i].typed) pending_results.push_back(stim_rows[i].want);
                else if (produced) pending_results.push_back(res);
            end
        end

        // widest row: width above range clamps to the line-store size
        write_reg(c3v_pkg::REG_KERNEL_TOP, rand_kernel_row());
        write_reg(c3v_pkg::REG_KERNEL_MIDDLE, rand_kernel_row());
        write_reg(c3v_pkg::REG_KERNEL_BOTTOM, rand_kernel_row());
        write_reg(c3v_pkg::REG_IMAGE_WIDTH, c3v_pkg::CFG_DATA_W'(WIDTH_FIELD_MAX));
        write_reg(c3v_pkg::REG_IMAGE_HEIGHT, c3v_pkg::CFG_DATA_W'(c3v_pkg::MIN_SIDE));
        repeat (c3v_pkg::MAX_WIDTH) feed_pixel(rand_pixel());

        // narrow rows under a height above range, long stretch with no idling
        write_reg(c3v_pkg::REG_IMAGE_WIDTH, c3v_pkg::CFG_DATA_W'(1));
        write_reg(c3v_pkg::REG_IMAGE_HEIGHT, c3v_pkg::CFG_DATA_W'(HEIGHT_FIELD_MAX));
        no_idle = 1'b1;
        repeat (TALL_ITEMS) feed_pixel(rand_pixel());
        no_idle = 1'b0;

        // random phases, settings changed between phases, often mid-image
        while (random_items < RANDOM_ITEMS) begin
            phase++;
            if ($urandom_range(0, 99) < 40)
                write_reg(c3v_pkg::REG_KERNEL_TOP, rand_kernel_row());
            if ($urandom_range(0, 99) < 40)
                write_reg(c3v_pkg::REG_KERNEL_MIDDLE, rand_kernel_row());
            if ($urandom_range(0, 99) < 40)
                write_reg(c3v_pkg::REG_KERNEL_BOTTOM, rand_kernel_row());
            if ($urandom_range(0, 99) < 40) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      w_val = c3v_pkg::WIDTH_REG_W'($urandom_range(0, 2));
                else if (pick < 25) w_val = c3v_pkg::WIDTH_REG_W'($urandom_range(11, 40));
                else                w_val = c3v_pkg::WIDTH_REG_W'($urandom_range(3, 10));
                // a wider row past the first one would read line-store columns never written
                if (row_cnt != 0 && width_clamp(w_val) > eff_width())
                    w_val = c3v_pkg::WIDTH_REG_W'($urandom_range(0, eff_width()));
                junk = c3v_pkg::CFG_DATA_W'({$urandom(), $urandom()});
                if ($urandom_range(0, 1))
                    write_reg(c3v_pkg::REG_IMAGE_WIDTH,
                              {junk[c3v_pkg::CFG_DATA_W-1:c3v_pkg::WIDTH_REG_W], w_val});
                else
                    write_reg(c3v_pkg::REG_IMAGE_WIDTH, c3v_pkg::CFG_DATA_W'(w_val));
            end
            if ($urandom_range(0, 99) < 40) begin
                pick = $urandom_range(0, 99);
                if (pick < 10)      h_val = c3v_pkg::HGT_REG_W'($urandom_range(0, 2));
                else if (pick < 15) h_val = c3v_pkg::HGT_REG_W'(
                                        $urandom_range(c3v_pkg::HEIGHT_LIMIT + 1,
                                                       HEIGHT_FIELD_MAX));
                else if (pick < 30) h_val = c3v_pkg::HGT_REG_W'($urandom_range(9, 30));
                else                h_val = c3v_pkg::HGT_REG_W'($urandom_range(3, 8));
                junk = c3v_pkg::CFG_DATA_W'({$urandom(), $urandom()});
                if ($urandom_range(0, 1))
                    write_reg(c3v_pkg::REG_IMAGE_HEIGHT,
                              {junk[c3v_pkg::CFG_DATA_W-1:c3v_pkg::HGT_REG_W], h_val});
                else
                    write_reg(c3v_pkg::REG_IMAGE_HEIGHT, c3v_pkg::CFG_DATA_W'(h_val));
            end

            hold_phase = (phase == 1) || ($urandom_range(0, 19) == 0);
            w = eff_width();
            h = eff_height();
            if (hold_phase) begin
                len = $urandom_range(80, 160);
            end else if ($urandom_range(0, 1)) begin
                // run to the end of the current image if that is at most 300 pixels
                len = ((col_cnt >= w) ? 1 : w - col_cnt) +
                      ((row_cnt + 1 >= h) ? 0 : (h - 1 - row_cnt) * w);
                if (len > 300) len = $urandom_range(1, 60);
            end else begin
                len = $urandom_range(1, 60);
            end
            pause_at = (phase == 2 || $urandom_range(0, 3) == 0) ?
                       $urandom_range(0, len - 1) : -1;
            if (hold_phase) hold_req++;

            for (int n = 0; n < len; n++) begin
                if (n == pause_at) drain_source();
                feed_pixel(rand_pixel());
                random_items++;
            end
        end

        drain_source();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_error($sformatf("%0d expected results never arrived",
                                 pending_results.size()));

        $display("run covered %0d pixel beats, %0d filtered results in %0d full images,",
                 pixels_sent, results_seen, frames_seen);
        $display("%0d register writes over %0d random phases, widths 3..1024, heights 3..4096",
                 cfg_writes, phase);
        if (errors == 0) begin
            $display("conv3x3_valid_stream_unit: match");
        end else begin
            $display("conv3x3_valid_stream_unit: mismatch");
        end
        $finish;
    end

endmodule
